/* sv/qip_pkg.sv */
// Shared types, constants and character-class functions for the
// qualified identifier parser. No dependencies.
package qip_pkg;

    // Longest identifier whose lengths are reported exactly.
    localparam int MAX_LEN = 4096;
    // Longest legal hostname label.
    localparam int LABEL_MAX = 63;

    // Width of the reported length fields.
    localparam int LEN_W = 13;
    // Internal counters hold MAX_LEN plus one for the overlong total.
    localparam int CNT_W = $clog2(MAX_LEN + 2);
    // Label length counter saturates at 127.
    localparam int LABEL_W = 7;

    // Parser region codes.
    localparam logic [1:0] REGION_REALM = 2'd0;
    localparam logic [1:0] REGION_PATH  = 2'd1;
    localparam logic [1:0] REGION_FRAG  = 2'd2;

    // Separator and punctuation characters.
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // One result of a finished identifier.
    typedef struct packed {
        logic             accepted;
        logic [LEN_W-1:0] realm_length;
        logic [LEN_W-1:0] path_length;
        logic             has_fragment;
        logic [LEN_W-1:0] fragment_length;
        logic             overlong;
    } t_result;

    // Lower-case ASCII letter.
    function automatic logic is_lower(input logic [7:0] c);
        return c inside {[8'h61:8'h7A]};
    endfunction

    // Decimal ASCII digit.
    function automatic logic is_decimal(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

endpackage

/* sv/qip_in_if.sv */
// Byte channel into the parser: valid/ready handshake with one byte
// and a last flag. Depends on nothing.
interface qip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       is_last;

    modport source (output valid, output character, output is_last, input ready);
    modport sink   (input valid, input character, input is_last, output ready);
endinterface

/* sv/qip_out_if.sv */
// Result channel out of the parser: valid/ready handshake with the
// verdict and part lengths. Depends on qip_pkg.
interface qip_out_if;
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [qip_pkg::LEN_W-1:0] realm_length;
    logic [qip_pkg::LEN_W-1:0] path_length;
    logic                      has_fragment;
    logic [qip_pkg::LEN_W-1:0] fragment_length;
    logic                      overlong;

    modport source (output valid, output accepted, output realm_length,
                    output path_length, output has_fragment,
                    output fragment_length, output overlong, input ready);
    modport sink   (input valid, input accepted, input realm_length,
                    input path_length, input has_fragment,
                    input fragment_length, input overlong, output ready);
endinterface

/* sv/qualified_identifier_parser.sv */
// Qualified identifier syntax checker: input register, byte scanner and
// result register. Depends on qip_pkg, qip_in_if, qip_out_if, qip_scanner.
// A result is registered in the result register when its last byte moves on from the input register.
// Throughput: one byte per cycle; bytes keep flowing while a result waits, and
// the input stalls only when a last byte meets a full result register not being read.
// Synchronous active-low reset empties both registers and restarts the scanner.
module qualified_identifier_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qip_in_if.sink    i_in,
    qip_out_if.source o_out
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_last;
    logic             r_out_valid;
    qip_pkg::t_result r_out;
    qip_pkg::t_result scan_result;
    logic             advance;

    // The held byte moves on unless it would produce a result into a full register.
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.character;
            r_in_last <= i_in.is_last;
        end
    end

    qip_scanner u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_character (r_in_char),
        .i_is_last   (r_in_last),
        .o_result    (scan_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= scan_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.accepted        = r_out.accepted;
    assign o_out.realm_length    = r_out.realm_length;
    assign o_out.path_length     = r_out.path_length;
    assign o_out.has_fragment    = r_out.has_fragment;
    assign o_out.fragment_length = r_out.fragment_length;
    assign o_out.overlong        = r_out.overlong;

`ifndef SYNTHESIS
    // A held byte that cannot move on keeps its contents.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_char)
                                      && $stable(r_in_last)))
        else $error("input register lost a stalled byte");

    // A new result appears only after a last byte has moved on.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_in_last))
        else $error("result appeared without a last byte");

    // An accepted identifier has at least two labels and a non-empty path.
    a_accept_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |->
            (o_out.realm_length >= 13'd3 && o_out.path_length != 13'd0))
        else $error("accepted identifier with impossible lengths");

    // Without a hash there is no fragment to count.
    a_fragment_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_fragment) |-> (o_out.fragment_length == 13'd0))
        else $error("fragment length without a fragment");
`endif

endmodule

/* sv/qip_scanner.sv */
// Per-byte syntax state of the parser: region, label and piece checks
// and saturating part counters. Depends on qip_pkg.
module qip_scanner (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_character,
    input  logic             i_is_last,
    output qip_pkg::t_result o_result
);

    logic [1:0]                  r_region,    n_region;
    logic [qip_pkg::LABEL_W-1:0] r_label_len, n_label_len;
    logic                        r_tail_ok,   n_tail_ok;
    logic [1:0]                  r_label_cnt, n_label_cnt;
    logic                        r_piece_ne,  n_piece_ne;
    logic                        r_failed,    n_failed;
    logic [qip_pkg::CNT_W-1:0]   r_realm_cnt, n_realm_cnt;
    logic [qip_pkg::CNT_W-1:0]   r_path_cnt,  n_path_cnt;
    logic [qip_pkg::CNT_W-1:0]   r_frag_cnt,  n_frag_cnt;
    logic                        r_exceeded,  n_exceeded;
    logic [qip_pkg::CNT_W-1:0]   r_total,     n_total;

    localparam logic [qip_pkg::CNT_W-1:0] CntMax = qip_pkg::CNT_W'(qip_pkg::MAX_LEN);
    localparam logic [qip_pkg::LABEL_W-1:0] LabelMax =
        qip_pkg::LABEL_W'(qip_pkg::LABEL_MAX);
    localparam logic [qip_pkg::LABEL_W-1:0] LabelSat = '1;

    logic c_lower, c_digit, c_word;

    // Character classes of the incoming byte.
    always_comb begin
        c_lower = qip_pkg::is_lower(i_character);
        c_digit = qip_pkg::is_decimal(i_character);
        c_word  = c_lower || c_digit || (i_character == qip_pkg::CH_DASH);
    end

    // Next state for one byte, in the order the grammar checks apply.
    always_comb begin
        n_region    = r_region;
        n_label_len = r_label_len;
        n_tail_ok   = r_tail_ok;
        n_label_cnt = r_label_cnt;
        n_piece_ne  = r_piece_ne;
        n_failed    = r_failed;
        n_realm_cnt = r_realm_cnt;
        n_path_cnt  = r_path_cnt;
        n_frag_cnt  = r_frag_cnt;
        n_exceeded  = r_exceeded;
        n_total     = r_total;

        if (r_total <= CntMax) begin
            n_total = r_total + 1'b1;
        end
        if (n_total > CntMax) begin
            n_exceeded = 1'b1;
        end

        case (r_region)
            qip_pkg::REGION_REALM: begin
                if (i_character == qip_pkg::CH_SLASH ||
                    i_character == qip_pkg::CH_DOT) begin
                    // Close the current label.
                    if (r_label_len == '0 || !r_tail_ok) begin
                        n_failed = 1'b1;
                    end else if (r_label_cnt < 2'd2) begin
                        n_label_cnt = r_label_cnt + 1'b1;
                    end
                    n_label_len = '0;
                    n_tail_ok   = 1'b0;
                    if (i_character == qip_pkg::CH_SLASH) begin
                        if (n_label_cnt < 2'd2) begin
                            n_failed = 1'b1;
                        end
                        n_region   = qip_pkg::REGION_PATH;
                        n_piece_ne = 1'b0;
                    end else if (r_realm_cnt < CntMax) begin
                        n_realm_cnt = r_realm_cnt + 1'b1;
                    end
                end else if (i_character == qip_pkg::CH_HASH) begin
                    n_failed   = 1'b1;
                    n_region   = qip_pkg::REGION_FRAG;
                    n_piece_ne = 1'b0;
                end else begin
                    if (r_realm_cnt < CntMax) begin
                        n_realm_cnt = r_realm_cnt + 1'b1;
                    end
                    if (r_label_len == '0) begin
                        if (!c_lower) begin
                            n_failed = 1'b1;
                        end
                    end else if (!c_word) begin
                        n_failed = 1'b1;
                    end
                    if (r_label_len >= LabelMax) begin
                        n_failed = 1'b1;
                    end
                    if (r_label_len != LabelSat) begin
                        n_label_len = r_label_len + 1'b1;
                    end
                    n_tail_ok = c_lower || c_digit;
                end
            end
            qip_pkg::REGION_PATH: begin
                if (i_character == qip_pkg::CH_HASH) begin
                    if (!r_piece_ne) begin
                        n_failed = 1'b1;
                    end
                    n_region   = qip_pkg::REGION_FRAG;
                    n_piece_ne = 1'b0;
                end else begin
                    if (r_path_cnt < CntMax) begin
                        n_path_cnt = r_path_cnt + 1'b1;
                    end
                    if (i_character == qip_pkg::CH_SLASH) begin
                        if (!r_piece_ne) begin
                            n_failed = 1'b1;
                        end
                        n_piece_ne = 1'b0;
                    end else begin
                        if (!c_word) begin
                            n_failed = 1'b1;
                        end
                        n_piece_ne = 1'b1;
                    end
                end
            end
            default: begin
                // Fragment region.
                if (r_frag_cnt < CntMax) begin
                    n_frag_cnt = r_frag_cnt + 1'b1;
                end
                if (!(c_word || i_character == qip_pkg::CH_DOT ||
                      i_character == qip_pkg::CH_UNDER ||
                      i_character == qip_pkg::CH_COLON)) begin
                    n_failed = 1'b1;
                end
                n_piece_ne = 1'b1;
            end
        endcase
    end

    // Verdict from the state after the last byte.
    always_comb begin
        o_result.accepted        = !n_failed && (n_region != qip_pkg::REGION_REALM)
                                   && n_piece_ne;
        o_result.realm_length    = n_realm_cnt[qip_pkg::LEN_W-1:0];
        o_result.path_length     = n_path_cnt[qip_pkg::LEN_W-1:0];
        o_result.has_fragment    = (n_region == qip_pkg::REGION_FRAG);
        o_result.fragment_length = n_frag_cnt[qip_pkg::LEN_W-1:0];
        o_result.overlong        = n_exceeded;
    end

    // State update; the last byte of an identifier clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_is_last)) begin
            r_region    <= qip_pkg::REGION_REALM;
            r_label_len <= '0;
            r_tail_ok   <= 1'b0;
            r_label_cnt <= '0;
            r_piece_ne  <= 1'b0;
            r_failed    <= 1'b0;
            r_realm_cnt <= '0;
            r_path_cnt  <= '0;
            r_frag_cnt  <= '0;
            r_exceeded  <= 1'b0;
            r_total     <= '0;
        end else if (i_step) begin
            r_region    <= n_region;
            r_label_len <= n_label_len;
            r_tail_ok   <= n_tail_ok;
            r_label_cnt <= n_label_cnt;
            r_piece_ne  <= n_piece_ne;
            r_failed    <= n_failed;
            r_realm_cnt <= n_realm_cnt;
            r_path_cnt  <= n_path_cnt;
            r_frag_cnt  <= n_frag_cnt;
            r_exceeded  <= n_exceeded;
            r_total     <= n_total;
        end
    end

endmodule
